// File: hw/rtl/ittw_pkg.sv
package ittw_pkg;

    localparam int ID_W     = 10;
    localparam int REQ_W    = 2;
    localparam int OC_W     = 3;
    localparam int CONN_IDS = 1 << ID_W;

    localparam logic [REQ_W-1:0] REQ_CLOSE = 2'd2;
    localparam logic [REQ_W-1:0] REQ_TICK  = 2'd3;

    localparam logic [OC_W-1:0] OC_PLACED    = 3'd0;
    localparam logic [OC_W-1:0] OC_ROW_FULL  = 3'd1;
    localparam logic [OC_W-1:0] OC_REMOVED   = 3'd2;
    localparam logic [OC_W-1:0] OC_EXPIRED   = 3'd3;
    localparam logic [OC_W-1:0] OC_IDLE_TICK = 3'd4;

endpackage

// File: hw/rtl/ittw_req_if.sv
interface ittw_req_if import ittw_pkg::*; ();

    logic             valid;
    logic             ready;
    logic [REQ_W-1:0] req_type;
    logic [ID_W-1:0]  conn_id;

    modport source (output valid, output req_type, output conn_id, input ready);
    modport sink   (input valid, input req_type, input conn_id, output ready);

endinterface

// File: hw/rtl/ittw_res_if.sv
interface ittw_res_if import ittw_pkg::*; ();

    logic            valid;
    logic            ready;
    logic [ID_W-1:0] conn_out;
    logic [OC_W-1:0] outcome;
    logic            last_of_run;

    modport source (output valid, output conn_out, output outcome, output last_of_run,
                    input ready);
    modport sink   (input valid, input conn_out, input outcome, input last_of_run,
                    output ready);

endinterface

// File: hw/rtl/idle_timeout_timing_wheel_top.sv
// Idle-timeout timing wheel: SLOTS rows of SITES entries in one row-wide memory, plus a
// per-connection location memory; one item is worked at a time. An activity or
// new-connection item reads its location, clears its old entry, reads the placement row,
// writes itself in and emits; a close emits after the clearing step; a tick reads the
// cursor row and emits an idle result if the row is empty, else one expired result per
// cycle while the output accepts them; the wheel memory's single read port sets these
// steps. A finished result waits in an output register while the next item is taken.
// No clearing pass follows reset: row valid bits in flip-flops stand in for the entry
// used bits; a location is only trusted when its wheel entry still holds that connection.
module idle_timeout_timing_wheel_top import ittw_pkg::*; #(
    parameter int SLOTS = 31,
    parameter int SITES = 10
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    ittw_req_if.sink        i_req,
    ittw_res_if.source      o_res
);

    localparam int RW  = $clog2(SLOTS);
    localparam int CW  = (SITES > 1) ? $clog2(SITES) : 1;
    localparam int WW  = SITES * (1 + ID_W);
    localparam int LW  = RW + CW;
    localparam logic [RW-1:0] LAST_ROW = RW'(SLOTS - 1);

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_CONN = 8'b0000_0010,
        S_OLD  = 8'b0000_0100,
        S_PRD  = 8'b0000_1000,
        S_PLC  = 8'b0001_0000,
        S_TRD  = 8'b0010_0000,
        S_TEXP = 8'b0100_0000,
        S_EMIT = 8'b1000_0000
    } t_state;

    t_state                     r_state, n_state;
    logic [RW-1:0]              r_cursor, n_cursor;
    logic [SLOTS-1:0]           r_row_vld, n_row_vld;
    logic [REQ_W-1:0]           r_req, n_req;
    logic [ID_W-1:0]            r_id, n_id;
    logic [RW-1:0]              r_old_row, n_old_row;
    logic [CW-1:0]              r_old_col, n_old_col;
    logic                       r_old_ok, n_old_ok;
    logic [SITES-1:0]           r_mask, n_mask;
    logic [SITES-1:0][ID_W-1:0] r_ids, n_ids;
    logic [ID_W-1:0]            r_res_id, n_res_id;
    logic [OC_W-1:0]            r_res_oc, n_res_oc;
    logic                       r_out_vld, n_out_vld;
    logic [ID_W-1:0]            r_out_id, n_out_id;
    logic [OC_W-1:0]            r_out_oc, n_out_oc;
    logic                       r_out_last, n_out_last;

    logic                       conn_we, conn_re;
    logic [ID_W-1:0]            conn_waddr, conn_raddr;
    logic [LW-1:0]              conn_wdata, conn_rdata;
    logic                       wheel_we, wheel_re;
    logic [RW-1:0]              wheel_waddr, wheel_raddr;
    logic [WW-1:0]              wheel_wdata, wheel_rdata;

    logic [SITES-1:0]           rd_used;
    logic [SITES-1:0][ID_W-1:0] rd_ids;
    logic [SITES-1:0][ID_W-1:0] plc_ids;
    logic [RW-1:0]              place_row;
    logic [SITES-1:0]           plc_mask;
    logic [CW-1:0]              free_col;
    logic                       free_found;
    logic [CW-1:0]              exp_col;
    logic [SITES-1:0]           exp_rest;
    logic [RW-1:0]              lk_row;
    logic [CW-1:0]              lk_col;
    logic                       lk_ok;
    logic                       out_free;
    logic                       in_xfer;

    ittw_ram #(.WIDTH(LW), .DEPTH(CONN_IDS)) u_conn_ram (
        .i_clk   (i_clk),
        .i_we    (conn_we),
        .i_waddr (conn_waddr),
        .i_wdata (conn_wdata),
        .i_re    (conn_re),
        .i_raddr (conn_raddr),
        .o_rdata (conn_rdata)
    );

    ittw_ram #(.WIDTH(WW), .DEPTH(SLOTS)) u_wheel_ram (
        .i_clk   (i_clk),
        .i_we    (wheel_we),
        .i_waddr (wheel_waddr),
        .i_wdata (wheel_wdata),
        .i_re    (wheel_re),
        .i_raddr (wheel_raddr),
        .o_rdata (wheel_rdata)
    );

    assign rd_used   = wheel_rdata[WW-1 -: SITES];
    assign rd_ids    = wheel_rdata[SITES*ID_W-1:0];
    assign place_row = (r_cursor == '0) ? LAST_ROW : r_cursor - 1'b1;
    assign plc_mask  = r_row_vld[place_row] ? rd_used : '0;
    assign lk_row    = conn_rdata[LW-1 -: RW];
    assign lk_col    = conn_rdata[CW-1:0];
    assign lk_ok     = ({1'b0, lk_row} < (RW+1)'(SLOTS)) && ({1'b0, lk_col} < (CW+1)'(SITES))
                       && r_row_vld[lk_row];
    assign out_free  = !r_out_vld || o_res.ready;
    assign in_xfer   = i_req.valid && i_req.ready;

    always_comb begin
        free_col   = '0;
        free_found = 1'b0;
        for (int c = SITES - 1; c >= 0; c--) begin
            if (!plc_mask[c]) begin
                free_col   = CW'(c);
                free_found = 1'b1;
            end
        end
    end

    always_comb begin
        exp_col = '0;
        for (int c = SITES - 1; c >= 0; c--) begin
            if (r_mask[c]) begin
                exp_col = CW'(c);
            end
        end
        exp_rest = r_mask & ~(SITES'(1) << exp_col);
    end

    always_comb begin
        n_state    = r_state;
        n_cursor   = r_cursor;
        n_row_vld  = r_row_vld;
        n_req      = r_req;
        n_id       = r_id;
        n_old_row  = r_old_row;
        n_old_col  = r_old_col;
        n_old_ok   = r_old_ok;
        n_mask     = r_mask;
        n_ids      = r_ids;
        n_res_id   = r_res_id;
        n_res_oc   = r_res_oc;
        n_out_vld  = r_out_vld && !o_res.ready;
        n_out_id   = r_out_id;
        n_out_oc   = r_out_oc;
        n_out_last = r_out_last;

        conn_we     = 1'b0;
        conn_waddr  = r_id;
        conn_wdata  = {place_row, free_col};
        conn_re     = 1'b0;
        conn_raddr  = i_req.conn_id;
        wheel_we    = 1'b0;
        wheel_waddr = place_row;
        wheel_wdata = '0;
        wheel_re    = 1'b0;
        wheel_raddr = r_cursor;
        plc_ids     = rd_ids;

        unique case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    n_req = i_req.req_type;
                    n_id  = i_req.conn_id;
                    if (i_req.req_type == REQ_TICK) begin
                        wheel_re = 1'b1;
                        n_state  = S_TRD;
                    end else begin
                        conn_re = 1'b1;
                        n_state = S_CONN;
                    end
                end
            end
            S_CONN: begin
                n_old_row   = lk_row;
                n_old_col   = lk_col;
                n_old_ok    = lk_ok;
                wheel_re    = 1'b1;
                wheel_raddr = lk_ok ? lk_row : '0;
                n_state     = S_OLD;
            end
            S_OLD: begin
                if (r_old_ok && rd_used[r_old_col] && rd_ids[r_old_col] == r_id) begin
                    wheel_we    = 1'b1;
                    wheel_waddr = r_old_row;
                    wheel_wdata = {rd_used & ~(SITES'(1) << r_old_col), rd_ids};
                end
                if (r_req == REQ_CLOSE) begin
                    n_res_id = r_id;
                    n_res_oc = OC_REMOVED;
                    n_state  = S_EMIT;
                end else begin
                    n_state = S_PRD;
                end
            end
            S_PRD: begin
                wheel_re    = 1'b1;
                wheel_raddr = place_row;
                n_state     = S_PLC;
            end
            S_PLC: begin
                n_res_id = r_id;
                if (free_found) begin
                    plc_ids[free_col]    = r_id;
                    wheel_we             = 1'b1;
                    wheel_wdata          = {plc_mask | (SITES'(1) << free_col), plc_ids};
                    n_row_vld[place_row] = 1'b1;
                    conn_we              = 1'b1;
                    n_res_oc             = OC_PLACED;
                end else begin
                    n_res_oc = OC_ROW_FULL;
                end
                n_state = S_EMIT;
            end
            S_TRD: begin
                n_mask              = r_row_vld[r_cursor] ? rd_used : '0;
                n_ids               = rd_ids;
                n_row_vld[r_cursor] = 1'b0;
                n_cursor            = (r_cursor == LAST_ROW) ? '0 : r_cursor + 1'b1;
                if (!r_row_vld[r_cursor] || rd_used == '0) begin
                    n_res_id = '0;
                    n_res_oc = OC_IDLE_TICK;
                    n_state  = S_EMIT;
                end else begin
                    n_state = S_TEXP;
                end
            end
            S_TEXP: begin
                if (out_free) begin
                    n_out_vld  = 1'b1;
                    n_out_id   = r_ids[exp_col];
                    n_out_oc   = OC_EXPIRED;
                    n_out_last = (exp_rest == '0);
                    n_mask     = exp_rest;
                    if (exp_rest == '0) begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    n_out_vld  = 1'b1;
                    n_out_id   = r_res_id;
                    n_out_oc   = r_res_oc;
                    n_out_last = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cursor  <= '0;
            r_row_vld <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cursor  <= n_cursor;
            r_row_vld <= n_row_vld;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req      <= n_req;
        r_id       <= n_id;
        r_old_row  <= n_old_row;
        r_old_col  <= n_old_col;
        r_old_ok   <= n_old_ok;
        r_mask     <= n_mask;
        r_ids      <= n_ids;
        r_res_id   <= n_res_id;
        r_res_oc   <= n_res_oc;
        r_out_id   <= n_out_id;
        r_out_oc   <= n_out_oc;
        r_out_last <= n_out_last;
    end

    assign i_req.ready       = (r_state == S_IDLE);
    assign o_res.valid       = r_out_vld;
    assign o_res.conn_out    = r_out_id;
    assign o_res.outcome     = r_out_oc;
    assign o_res.last_of_run = r_out_last;

endmodule

// File: hw/rtl/ittw_ram.sv
module ittw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic                                   i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
